@@ design/m2m_pkg.sv @@
// Package for the MUS to MIDI track transcoder.
// Holds the item types, the parser phase type, result kind codes and the
// constant event tables. Depends on nothing.
package m2m_pkg;

  // Fixed sizes of the block.
  localparam int CHANNELS     = 16;
  localparam int LENGTH_BITS  = 24;
  localparam int RUN_MAX      = 12;
  localparam int RUN_W        = 4;
  localparam int TEMPO_LEN    = 7;
  localparam int DELTA_W      = 28;
  localparam int VOL_W        = 7;

  // Result kind codes.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // MIDI status and meta bytes.
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_CTRL      = 8'hb0;
  localparam logic [7:0] ST_PROGRAM   = 8'hc0;
  localparam logic [7:0] ST_BEND      = 8'he0;
  localparam logic [7:0] META_PREFIX  = 8'hff;
  localparam logic [7:0] META_EOT     = 8'h2f;
  localparam logic [VOL_W-1:0] VOL_DEFAULT = 7'd100;

  // MUS event types, taken from descriptor bits 6:4.
  localparam logic [2:0] EV_RELEASE = 3'd0;
  localparam logic [2:0] EV_PLAY    = 3'd1;
  localparam logic [2:0] EV_BEND    = 3'd2;
  localparam logic [2:0] EV_SYSTEM  = 3'd3;
  localparam logic [2:0] EV_CTRL    = 3'd4;
  localparam logic [2:0] EV_END     = 3'd6;

  // Tempo meta event: 500000 us per quarter note.
  localparam logic [7:0] TEMPO_EVENT [TEMPO_LEN] =
    '{8'h00, 8'hff, 8'h51, 8'h03, 8'h07, 8'ha1, 8'h20};

  typedef enum logic [2:0] {
    PH_DESC,
    PH_DATA1,
    PH_VOL,
    PH_DATA2,
    PH_DELAY,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [7:0] score_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  midi_byte;
    logic [1:0]  out_kind;
    logic [23:0] track_length;
    logic        last_of_run;
  } out_item_t;

  // MUS system event numbers 10 to 14 mapped to MIDI controller numbers.
  function automatic logic [7:0] sys_map(input logic [6:0] ev);
    logic [7:0] res;
    case (ev)
      7'd10:   res = 8'd120;
      7'd11:   res = 8'd123;
      7'd12:   res = 8'd126;
      7'd13:   res = 8'd127;
      7'd14:   res = 8'd121;
      default: res = 8'd0;
    endcase
    return res;
  endfunction

  // MUS controller numbers 1 to 9 mapped to MIDI controller numbers.
  function automatic logic [7:0] ctrl_map(input logic [6:0] num);
    logic [7:0] res;
    case (num)
      7'd1:    res = 8'd0;
      7'd2:    res = 8'd1;
      7'd3:    res = 8'd7;
      7'd4:    res = 8'd10;
      7'd5:    res = 8'd11;
      7'd6:    res = 8'd91;
      7'd7:    res = 8'd93;
      7'd8:    res = 8'd64;
      7'd9:    res = 8'd67;
      default: res = 8'd0;
    endcase
    return res;
  endfunction

  // MUS percussion sits on channel 15, MIDI percussion on channel 9.
  function automatic logic [3:0] midi_channel(input logic [3:0] ch);
    logic [3:0] res;
    case (ch)
      4'd15:   res = 4'd9;
      4'd9:    res = 4'd15;
      default: res = ch;
    endcase
    return res;
  endfunction

endpackage

@@ design/mus_to_midi_transcoder.sv @@
// A score item is registered at acceptance and parsed from the input register; its results
// are registered in the run buffer and handed out from there. Throughput: one score item per
// cycle while items cause no results; an item causing results holds the output until they
// are all taken or stalled out, and the next item is taken while the last result of a run is
// being handed out.
// Reset clears the parser to await a song, all channel volumes to 100 and the length count.
module mus_to_midi_transcoder #(
  parameter int LENGTH_BITS = m2m_pkg::LENGTH_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  m2m_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output m2m_pkg::out_item_t  out_item
);

  localparam int RW = m2m_pkg::RUN_W;
  localparam int DW = m2m_pkg::DELTA_W;
  localparam int VW = m2m_pkg::VOL_W;
  localparam logic [DW-1:0] DELTA_MAX = {DW{1'b1}};

  // Input register stage.
  logic                s1_valid_r;
  m2m_pkg::in_item_t   s1_r;
  logic                s1_adv;

  // Parser state.
  m2m_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]          held_desc_r, held_desc_nxt;
  logic [6:0]          held_data_r, held_data_nxt;
  logic [DW-1:0]       delta_r, delta_nxt;
  logic [VW-1:0]       vol_r [m2m_pkg::CHANNELS];
  logic                started_r, started_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;

  // Output run buffer.
  logic [7:0]          run_r [m2m_pkg::RUN_MAX];
  logic [RW-1:0]       nbytes_r;
  logic [RW-1:0]       total_r;
  logic [RW-1:0]       idx_r;
  logic [1:0]          tail_kind_r;
  logic [23:0]         len_r;
  logic                busy_r;

  // Parse results for the item in the input register.
  logic [7:0]          rb [m2m_pkg::RUN_MAX];
  logic [RW-1:0]       pos;
  logic [RW-1:0]       total;
  logic                song_start;
  logic                vol_we;
  logic [VW-1:0]       vol_wdata;
  logic                ev_fire;
  logic [7:0]          ev_status;
  logic [7:0]          ev_a;
  logic [7:0]          ev_b;
  logic                ev_two;
  logic                err;
  logic                done;
  logic [2:0]          vlq_n;
  logic [6:0]          g0, g1, g2, g3;
  logic [LENGTH_BITS-1:0] count_base;
  logic [LENGTH_BITS:0]   count_sum;
  logic [3:0]          ch;
  logic [7:0]          sb;
  logic                out_last;
  logic                buf_free;

  assign sb = s1_r.score_byte;
  assign ch = held_desc_r[3:0];

  // Delta time split into seven-bit groups for the variable-length quantity.
  assign g0 = delta_r[6:0];
  assign g1 = delta_r[13:7];
  assign g2 = delta_r[20:14];
  assign g3 = delta_r[27:21];
  always_comb begin
    if (g3 != 7'd0) begin
      vlq_n = 3'd4;
    end else if (g2 != 7'd0) begin
      vlq_n = 3'd3;
    end else if (g1 != 7'd0) begin
      vlq_n = 3'd2;
    end else begin
      vlq_n = 3'd1;
    end
  end

  // Handshake between the input register, the run buffer and the output.
  assign out_valid = busy_r;
  assign out_last  = (idx_r == total_r - RW'(1));
  assign buf_free  = !busy_r || (out_last && !out_stall);
  assign s1_adv    = s1_valid_r && (buf_free || (total == '0));
  assign in_stall  = s1_valid_r && !s1_adv;

  // Parser: next state and the run of results for one score item.
  always_comb begin
    phase_nxt     = phase_r;
    held_desc_nxt = held_desc_r;
    held_data_nxt = held_data_r;
    delta_nxt     = delta_r;
    started_nxt   = started_r;
    song_start    = 1'b0;
    vol_we        = 1'b0;
    vol_wdata     = sb[6:0];
    ev_fire       = 1'b0;
    ev_status     = m2m_pkg::ST_NOTE_OFF;
    ev_a          = 8'd0;
    ev_b          = 8'd0;
    ev_two        = 1'b1;
    err           = 1'b0;
    done          = 1'b0;
    pos           = '0;
    for (int i = 0; i < m2m_pkg::RUN_MAX; i++) begin
      rb[i] = 8'd0;
    end

    case (phase_r)
      m2m_pkg::PH_DESC: begin
        if (!started_r) begin
          song_start  = 1'b1;
          started_nxt = 1'b1;
          delta_nxt   = '0;
          for (int i = 0; i < m2m_pkg::TEMPO_LEN; i++) begin
            rb[i] = m2m_pkg::TEMPO_EVENT[i];
          end
          pos = RW'(m2m_pkg::TEMPO_LEN);
        end
        held_desc_nxt = sb;
        case (sb[6:4])
          m2m_pkg::EV_RELEASE, m2m_pkg::EV_PLAY, m2m_pkg::EV_BEND,
          m2m_pkg::EV_SYSTEM, m2m_pkg::EV_CTRL: begin
            phase_nxt = m2m_pkg::PH_DATA1;
          end
          m2m_pkg::EV_END: begin
            rb[pos] = 8'h00;
            pos = pos + RW'(1);
            rb[pos] = m2m_pkg::META_PREFIX;
            pos = pos + RW'(1);
            rb[pos] = m2m_pkg::META_EOT;
            pos = pos + RW'(1);
            rb[pos] = 8'h00;
            pos = pos + RW'(1);
            done = 1'b1;
            phase_nxt = m2m_pkg::PH_SKIP;
          end
          default: begin
            err = 1'b1;
            phase_nxt = m2m_pkg::PH_SKIP;
          end
        endcase
      end
      m2m_pkg::PH_DATA1: begin
        case (held_desc_r[6:4])
          m2m_pkg::EV_RELEASE: begin
            ev_fire   = 1'b1;
            ev_status = m2m_pkg::ST_NOTE_OFF;
            ev_a      = {1'b0, sb[6:0]};
          end
          m2m_pkg::EV_PLAY: begin
            held_data_nxt = sb[6:0];
            if (sb[7]) begin
              phase_nxt = m2m_pkg::PH_VOL;
            end else begin
              ev_fire   = 1'b1;
              ev_status = m2m_pkg::ST_NOTE_ON;
              ev_a      = {1'b0, sb[6:0]};
              ev_b      = {1'b0, vol_r[ch]};
            end
          end
          m2m_pkg::EV_BEND: begin
            ev_fire   = 1'b1;
            ev_status = m2m_pkg::ST_BEND;
            ev_a      = {1'b0, sb[0], 6'd0};
            ev_b      = {1'b0, sb[7:1]};
          end
          m2m_pkg::EV_SYSTEM: begin
            if (sb[6:0] < 7'd10 || sb[6:0] > 7'd14) begin
              err = 1'b1;
              phase_nxt = m2m_pkg::PH_SKIP;
            end else begin
              ev_fire   = 1'b1;
              ev_status = m2m_pkg::ST_CTRL;
              ev_a      = m2m_pkg::sys_map(sb[6:0]);
            end
          end
          default: begin
            held_data_nxt = sb[6:0];
            phase_nxt = m2m_pkg::PH_DATA2;
          end
        endcase
      end
      m2m_pkg::PH_VOL: begin
        vol_we    = 1'b1;
        ev_fire   = 1'b1;
        ev_status = m2m_pkg::ST_NOTE_ON;
        ev_a      = {1'b0, held_data_r};
        ev_b      = {1'b0, sb[6:0]};
      end
      m2m_pkg::PH_DATA2: begin
        if (held_data_r == 7'd0) begin
          ev_fire   = 1'b1;
          ev_status = m2m_pkg::ST_PROGRAM;
          ev_a      = {1'b0, sb[6:0]};
          ev_two    = 1'b0;
        end else if (held_data_r < 7'd10) begin
          ev_fire   = 1'b1;
          ev_status = m2m_pkg::ST_CTRL;
          ev_a      = m2m_pkg::ctrl_map(held_data_r);
          ev_b      = {1'b0, sb[6:0]};
        end else begin
          err = 1'b1;
          phase_nxt = m2m_pkg::PH_SKIP;
        end
      end
      m2m_pkg::PH_DELAY: begin
        if (delta_r > (DELTA_MAX >> 7)) begin
          delta_nxt = DELTA_MAX;
        end else begin
          delta_nxt = {delta_r[DW-8:0], sb[6:0]};
        end
        if (!sb[7]) begin
          phase_nxt = m2m_pkg::PH_DESC;
        end
      end
      default: begin
      end
    endcase

    // Channel event: delta time, status with mapped channel, one or two data bytes.
    if (ev_fire) begin
      if (vlq_n == 3'd4) begin
        rb[pos] = {1'b1, g3};
        pos = pos + RW'(1);
      end
      if (vlq_n >= 3'd3) begin
        rb[pos] = {1'b1, g2};
        pos = pos + RW'(1);
      end
      if (vlq_n >= 3'd2) begin
        rb[pos] = {1'b1, g1};
        pos = pos + RW'(1);
      end
      rb[pos] = {1'b0, g0};
      pos = pos + RW'(1);
      rb[pos] = ev_status | {4'd0, m2m_pkg::midi_channel(ch)};
      pos = pos + RW'(1);
      rb[pos] = ev_a;
      pos = pos + RW'(1);
      if (ev_two) begin
        rb[pos] = ev_b;
        pos = pos + RW'(1);
      end
      delta_nxt = '0;
      phase_nxt = held_desc_r[7] ? m2m_pkg::PH_DELAY : m2m_pkg::PH_DESC;
    end

    // The last byte of a score rearms the parser; an unfinished song is an error.
    if (s1_r.final_byte) begin
      if (phase_nxt != m2m_pkg::PH_SKIP) begin
        err = 1'b1;
      end
      phase_nxt   = m2m_pkg::PH_DESC;
      started_nxt = 1'b0;
      delta_nxt   = '0;
    end

    total = pos + RW'(err || done);
  end

  // Track byte count, saturating at the length width.
  assign count_base = song_start ? '0 : count_r;
  assign count_sum  = {1'b0, count_base} + (LENGTH_BITS + 1)'(pos);
  assign count_nxt  = count_sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}}
                                             : count_sum[LENGTH_BITS-1:0];

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_item;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= m2m_pkg::PH_DESC;
      held_desc_r <= 8'd0;
      held_data_r <= 7'd0;
      delta_r     <= '0;
      started_r   <= 1'b0;
      count_r     <= '0;
    end else if (s1_adv) begin
      phase_r     <= phase_nxt;
      held_desc_r <= held_desc_nxt;
      held_data_r <= held_data_nxt;
      delta_r     <= delta_nxt;
      started_r   <= started_nxt;
      count_r     <= count_nxt;
    end
  end

  // Channel volumes: all reset at song start, one written by a play with volume.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < m2m_pkg::CHANNELS; i++) begin
        vol_r[i] <= m2m_pkg::VOL_DEFAULT;
      end
    end else if (s1_adv) begin
      if (song_start) begin
        for (int i = 0; i < m2m_pkg::CHANNELS; i++) begin
          vol_r[i] <= m2m_pkg::VOL_DEFAULT;
        end
      end else if (vol_we) begin
        vol_r[ch] <= vol_wdata;
      end
    end
  end

  // Run buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      total_r <= '0;
    end else if (s1_adv && (total != '0)) begin
      busy_r  <= 1'b1;
      idx_r   <= '0;
      total_r <= total;
    end else if (busy_r && !out_stall) begin
      if (out_last) begin
        busy_r <= 1'b0;
      end
      idx_r <= idx_r + RW'(1);
    end
  end

  // Run buffer payload.
  always_ff @(posedge clk) begin
    if (s1_adv && (total != '0)) begin
      for (int i = 0; i < m2m_pkg::RUN_MAX; i++) begin
        run_r[i] <= rb[i];
      end
      nbytes_r    <= pos;
      tail_kind_r <= err ? m2m_pkg::KIND_ERROR : m2m_pkg::KIND_DONE;
      len_r       <= 24'(count_nxt);
    end
  end

  // Output item: the track bytes of the run, then a finish or error result if the run has one.
  always_comb begin
    if (idx_r < nbytes_r) begin
      out_item.midi_byte    = run_r[idx_r];
      out_item.out_kind     = m2m_pkg::KIND_BYTE;
      out_item.track_length = 24'd0;
    end else begin
      out_item.midi_byte    = 8'd0;
      out_item.out_kind     = tail_kind_r;
      out_item.track_length = (tail_kind_r == m2m_pkg::KIND_DONE) ? len_r : 24'd0;
    end
    out_item.last_of_run = out_last;
  end

  // A pending run never points past its end.
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < total_r))
    else $error("run index beyond run length");

  // A finished or failed song can only follow a started one.
  a_skip_started: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == m2m_pkg::PH_SKIP) |-> started_r)
    else $error("skip phase without a started song");

  // Finish and error results always close their run.
  a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.out_kind != m2m_pkg::KIND_BYTE)) |-> out_item.last_of_run)
    else $error("status result not last of run");

  // A score byte that was stalled is parsed once the buffer frees up.
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !busy_r) |-> !in_stall)
    else $error("input stalled while the run buffer is empty");

endmodule

@@ test/mus_to_midi_transcoder_tb.sv @@
// Self-checking bench for the MUS to MIDI track transcoder: directed and random scores.
// Expected track bytes come from an in-bench transcoder, with random idling on both sides.
// Depends on m2m_pkg and mus_to_midi_transcoder.
`timescale 1ns / 1ps

module mus_to_midi_transcoder_tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS = 62;

  // Event types that MUS leaves undefined.
  localparam logic [2:0] EV_UNDEF_A = 3'd5;
  localparam logic [2:0] EV_UNDEF_B = 3'd7;

  // Percussion channel numbers on each side.
  localparam logic [3:0] PERC_MUS  = 4'd15;
  localparam logic [3:0] PERC_MIDI = 4'd9;

  // Valid system event and controller number ranges.
  localparam logic [6:0] SYS_FIRST  = 7'd10;
  localparam logic [6:0] SYS_LAST   = 7'd14;
  localparam logic [6:0] CTRL_COUNT = 7'd10;
  localparam logic [27:0] DELTA_SAT = 28'hfffffff;

  localparam logic [7:0] CTRL_NUM [10] = '{8'd0, 8'd0, 8'd1, 8'd7, 8'd10, 8'd11,
                                          8'd91, 8'd93, 8'd64, 8'd67};
  localparam logic [7:0] SYS_NUM [5] = '{8'd120, 8'd123, 8'd126, 8'd127, 8'd121};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  m2m_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  m2m_pkg::out_item_t out_item;

  mus_to_midi_transcoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Score items waiting to be sent, a song under construction, and the expected track.
  m2m_pkg::in_item_t score_q[$];
  m2m_pkg::in_item_t song_buf[$];
  m2m_pkg::out_item_t midi_q[$];
  m2m_pkg::out_item_t run_buf[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Transcoder state mirrored by the bench.
  m2m_pkg::phase_t parse_ph = m2m_pkg::PH_DESC;
  logic [7:0] desc_reg = '0;
  logic [7:0] data_reg = '0;
  logic [27:0] delta_reg = '0;
  logic [m2m_pkg::VOL_W-1:0] chan_vol [m2m_pkg::CHANNELS];
  bit in_song = 1'b0;
  logic [23:0] byte_count = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void put_result(logic [7:0] b, logic [1:0] kind, logic [23:0] len);
    m2m_pkg::out_item_t r;
    if (run_buf.size() >= m2m_pkg::RUN_MAX) return;
    r.midi_byte = b;
    r.out_kind = kind;
    r.track_length = len;
    r.last_of_run = 1'b0;
    run_buf.push_back(r);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    put_result(b, m2m_pkg::KIND_BYTE, '0);
    if (byte_count != '1) byte_count = byte_count + 1'b1;
  endfunction

  // Delta time as a variable-length quantity, most significant group first.
  function automatic void put_delta(logic [27:0] v);
    logic [6:0] grp [4];
    int n;
    n = 0;
    do begin
      grp[n] = v[6:0];
      v = v >> 7;
      n++;
    end while (v != 0 && n < 4);
    while (n > 1) begin
      n--;
      put_byte({1'b1, grp[n]});
    end
    put_byte({1'b0, grp[0]});
  endfunction

  function automatic void put_event(logic [7:0] status, bit two_data, logic [7:0] a,
                                    logic [7:0] b);
    logic [3:0] ch;
    ch = desc_reg[3:0];
    if (ch == PERC_MUS) ch = PERC_MIDI;
    else if (ch == PERC_MIDI) ch = PERC_MUS;
    put_delta(delta_reg);
    put_byte(status | {4'h0, ch});
    put_byte(a);
    if (two_data) put_byte(b);
    delta_reg = '0;
    parse_ph = desc_reg[7] ? m2m_pkg::PH_DELAY : m2m_pkg::PH_DESC;
  endfunction

  function automatic void put_error();
    put_result('0, m2m_pkg::KIND_ERROR, '0);
    parse_ph = m2m_pkg::PH_SKIP;
  endfunction

  // Works out the track items caused by one score item and queues them.
  function automatic void transcode_byte(m2m_pkg::in_item_t it);
    logic [7:0] b;
    logic [3:0] ch;
    b = it.score_byte;
    ch = desc_reg[3:0];
    run_buf.delete();
    case (parse_ph)
      m2m_pkg::PH_DESC: begin
        if (!in_song) begin
          foreach (chan_vol[i]) chan_vol[i] = m2m_pkg::VOL_DEFAULT;
          delta_reg = '0;
          byte_count = '0;
          in_song = 1'b1;
          for (int i = 0; i < m2m_pkg::TEMPO_LEN; i++) put_byte(m2m_pkg::TEMPO_EVENT[i]);
        end
        desc_reg = b;
        case (b[6:4])
          m2m_pkg::EV_RELEASE, m2m_pkg::EV_PLAY, m2m_pkg::EV_BEND, m2m_pkg::EV_SYSTEM,
          m2m_pkg::EV_CTRL: parse_ph = m2m_pkg::PH_DATA1;
          m2m_pkg::EV_END: begin
            put_delta('0);
            put_byte(m2m_pkg::META_PREFIX);
            put_byte(m2m_pkg::META_EOT);
            put_byte(8'h00);
            put_result('0, m2m_pkg::KIND_DONE, byte_count);
            parse_ph = m2m_pkg::PH_SKIP;
          end
          default: put_error();
        endcase
      end
      m2m_pkg::PH_DATA1: begin
        case (desc_reg[6:4])
          m2m_pkg::EV_RELEASE: put_event(m2m_pkg::ST_NOTE_OFF, 1'b1, {1'b0, b[6:0]}, '0);
          m2m_pkg::EV_PLAY: begin
            data_reg = {1'b0, b[6:0]};
            if (b[7]) parse_ph = m2m_pkg::PH_VOL;
            else put_event(m2m_pkg::ST_NOTE_ON, 1'b1, data_reg, {1'b0, chan_vol[ch]});
          end
          m2m_pkg::EV_BEND: put_event(m2m_pkg::ST_BEND, 1'b1, {1'b0, b[0], 6'd0},
                                      {1'b0, b[7:1]});
          m2m_pkg::EV_SYSTEM: begin
            if (b[6:0] < SYS_FIRST || b[6:0] > SYS_LAST) put_error();
            else put_event(m2m_pkg::ST_CTRL, 1'b1, SYS_NUM[b[6:0] - SYS_FIRST], '0);
          end
          default: begin
            data_reg = {1'b0, b[6:0]};
            parse_ph = m2m_pkg::PH_DATA2;
          end
        endcase
      end
      m2m_pkg::PH_VOL: begin
        chan_vol[ch] = b[6:0];
        put_event(m2m_pkg::ST_NOTE_ON, 1'b1, data_reg, {1'b0, b[6:0]});
      end
      m2m_pkg::PH_DATA2: begin
        if (data_reg == 0) put_event(m2m_pkg::ST_PROGRAM, 1'b0, {1'b0, b[6:0]}, '0);
        else if (data_reg < CTRL_COUNT) put_event(m2m_pkg::ST_CTRL, 1'b1, CTRL_NUM[data_reg],
                                                  {1'b0, b[6:0]});
        else put_error();
      end
      m2m_pkg::PH_DELAY: begin
        // The delta saturates once another 7-bit group would overflow 28 bits.
        if (delta_reg > (DELTA_SAT >> 7)) delta_reg = DELTA_SAT;
        else delta_reg = {delta_reg[20:0], b[6:0]};
        if (!b[7]) parse_ph = m2m_pkg::PH_DESC;
      end
      default: ;
    endcase
    // The last score byte rearms for a new song; an unfinished song is an error.
    if (it.final_byte) begin
      if (parse_ph != m2m_pkg::PH_SKIP) put_error();
      parse_ph = m2m_pkg::PH_DESC;
      in_song = 1'b0;
      delta_reg = '0;
    end
    if (run_buf.size() > 0) run_buf[run_buf.size() - 1].last_of_run = 1'b1;
    foreach (run_buf[i]) midi_q.push_back(run_buf[i]);
  endfunction

  // Driver: offers queued score items and predicts each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) transcode_byte(in_item);
      if (!in_valid || !in_stall) begin
        if (score_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item <= score_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each taken track item with the oldest expected one.
  always @(posedge clk) begin : track_check
    m2m_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (midi_q.size() == 0) begin
          $error("unexpected item: midi_byte %02h out_kind %0d track_length %0d",
                 out_item.midi_byte, out_item.out_kind, out_item.track_length);
          mismatch_count++;
        end else begin
          want = midi_q.pop_front();
          if (out_item.midi_byte !== want.midi_byte) begin
            $error("midi_byte: expected %02h, got %02h", want.midi_byte, out_item.midi_byte);
            mismatch_count++;
          end
          if (out_item.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0d, got %0d", want.out_kind, out_item.out_kind);
            mismatch_count++;
          end
          if (out_item.track_length !== want.track_length) begin
            $error("track_length: expected %0d, got %0d", want.track_length,
                   out_item.track_length);
            mismatch_count++;
          end
          if (out_item.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                   out_item.last_of_run);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mus_to_midi_transcoder: mismatch");
      $finish;
    end
  end

  task automatic push_score(logic [7:0] b, bit fin);
    m2m_pkg::in_item_t it;
    it.score_byte = b;
    it.final_byte = fin;
    song_buf.push_back(it);
  endtask

  task automatic flush_song();
    foreach (song_buf[i]) score_q.push_back(song_buf[i]);
  endtask

  // One MUS event with random content; a broken one carries a bad type or number.
  task automatic add_event(bit broken);
    logic [3:0] ch;
    logic [2:0] kind;
    logic [7:0] b;
    bit delayed;
    int n_delay;
    int i;
    ch = 4'($urandom);
    delayed = ($urandom_range(0, 2) == 0);
    if (broken) begin
      case ($urandom_range(0, 2))
        0: push_score({1'($urandom), ($urandom_range(0, 1) ? EV_UNDEF_A : EV_UNDEF_B), ch},
                      1'b0);
        1: begin
          push_score({delayed, m2m_pkg::EV_SYSTEM, ch}, 1'b0);
          b = 8'($urandom);
          if (b[6:0] >= SYS_FIRST && b[6:0] <= SYS_LAST) b[6:0] = 7'($urandom_range(15, 127));
          push_score(b, 1'b0);
        end
        default: begin
          push_score({delayed, m2m_pkg::EV_CTRL, ch}, 1'b0);
          push_score({1'($urandom), 7'($urandom_range(10, 127))}, 1'b0);
          push_score(8'($urandom), 1'b0);
        end
      endcase
      return;
    end
    kind = 3'($urandom_range(0, 4));
    push_score({delayed, kind, ch}, 1'b0);
    case (kind)
      m2m_pkg::EV_PLAY: begin
        b = 8'($urandom);
        push_score(b, 1'b0);
        if (b[7]) push_score(8'($urandom), 1'b0);
      end
      m2m_pkg::EV_SYSTEM: push_score({1'($urandom), 7'($urandom_range(10, 14))}, 1'b0);
      m2m_pkg::EV_CTRL: begin
        push_score({1'($urandom), 7'($urandom_range(0, 9))}, 1'b0);
        push_score(8'($urandom), 1'b0);
      end
      default: push_score(8'($urandom), 1'b0);
    endcase
    // Delay groups: usually short, sometimes long enough to saturate.
    if (delayed) begin
      n_delay = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
      for (i = 0; i < n_delay - 1; i++) push_score({1'b1, 7'($urandom)}, 1'b0);
      push_score({1'b0, 7'($urandom)}, 1'b0);
    end
  endtask

  // A song is mostly well formed; some are noise, carry a bad event or are cut short.
  task automatic add_random_song();
    int n_events;
    int mode;
    int bad_at;
    int body_len;
    int cut;
    int i;
    song_buf.delete();
    n_events = $urandom_range(1, 10);
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(0, 3)) push_score(8'($urandom), 1'b0);
      push_score(8'($urandom), 1'b1);
    end else begin
      bad_at = (mode == 1) ? $urandom_range(0, n_events - 1) : -1;
      for (i = 0; i < n_events; i++) add_event(i == bad_at);
      body_len = song_buf.size();
      if (mode == 2) begin
        cut = $urandom_range(0, body_len - 1);
        while (song_buf.size() > cut + 1) void'(song_buf.pop_back());
        song_buf[cut].final_byte = 1'b1;
      end else if ($urandom_range(0, 1)) begin
        push_score({1'($urandom), m2m_pkg::EV_END, 4'($urandom)}, 1'b1);
      end else begin
        push_score({1'($urandom), m2m_pkg::EV_END, 4'($urandom)}, 1'b0);
        repeat ($urandom_range(0, 2)) push_score(8'($urandom), 1'b0);
        push_score(8'($urandom), 1'b1);
      end
    end
    flush_song();
  endtask

  // Holds the sender until every queued item is taken and every track item has come.
  task automatic wait_drained();
    while (score_q.size() != 0 || in_valid) @(posedge clk);
    while (midi_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall, int n_items);
    int added;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    added = 0;
    while (added < n_items) begin
      add_random_song();
      added += song_buf.size();
    end
    wait_drained();
  endtask

  initial begin
    foreach (chan_vol[i]) chan_vol[i] = m2m_pkg::VOL_DEFAULT;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed song: release with a saturating delay, play with and without a volume,
    // percussion channel swap, a full-scale bend, a system event, a program change, and
    // score end on the last byte.
    song_buf.delete();
    push_score({1'b1, m2m_pkg::EV_RELEASE, 4'd0}, 1'b0);
    push_score(8'hff, 1'b0);
    push_score(8'hff, 1'b0);
    push_score(8'hff, 1'b0);
    push_score(8'hff, 1'b0);
    push_score(8'hff, 1'b0);
    push_score(8'h7f, 1'b0);
    push_score({1'b0, m2m_pkg::EV_PLAY, PERC_MUS}, 1'b0);
    push_score(8'hff, 1'b0);
    push_score(8'h7f, 1'b0);
    push_score({1'b0, m2m_pkg::EV_PLAY, PERC_MIDI}, 1'b0);
    push_score(8'h00, 1'b0);
    push_score({1'b0, m2m_pkg::EV_BEND, 4'd3}, 1'b0);
    push_score(8'hff, 1'b0);
    push_score({1'b0, m2m_pkg::EV_SYSTEM, 4'd1}, 1'b0);
    push_score({1'b1, SYS_LAST}, 1'b0);
    push_score({1'b0, m2m_pkg::EV_CTRL, 4'd5}, 1'b0);
    push_score(8'h00, 1'b0);
    push_score(8'h7f, 1'b0);
    push_score({1'b0, m2m_pkg::EV_END, 4'd0}, 1'b1);
    // The volume returns to its default in a new song; then an undefined event type,
    // and a score cut short right after its first descriptor.
    push_score({1'b0, m2m_pkg::EV_PLAY, PERC_MUS}, 1'b0);
    push_score(8'h00, 1'b0);
    push_score({1'b0, EV_UNDEF_B, 4'd0}, 1'b0);
    push_score(8'h00, 1'b1);
    push_score({1'b0, m2m_pkg::EV_RELEASE, 4'd0}, 1'b1);
    flush_song();
    wait_drained();

    // Random scores under each idling pattern.
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(56, 0, PHASE_ITEMS);
    run_phase(0, 56, PHASE_ITEMS);
    run_phase(16, 16, PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mus_to_midi_transcoder: match");
    end else begin
      $display("mus_to_midi_transcoder: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/m2m_pkg.sv
design/mus_to_midi_transcoder.sv
test/mus_to_midi_transcoder_tb.sv
